// ===== hdl/hkrd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkrd_pkg
// Shared types, sizes and helpers for the keyboard report differ.
// ----------------------------------------------------------------------------
package hkrd_pkg;

    localparam int KEY_SLOTS  = 6;
    localparam int EVENT_BITS = 2 * KEY_SLOTS;
    localparam int FLAG_W     = 6;

    // Modifier byte bit positions that carry a decoded flag.
    localparam int MOD_LCTRL  = 0;
    localparam int MOD_LSHIFT = 1;
    localparam int MOD_ALT    = 2;
    localparam int MOD_RCTRL  = 4;
    localparam int MOD_RSHIFT = 5;
    localparam int MOD_ALTGR  = 6;

    typedef logic [7:0]                  key_t;
    typedef key_t [KEY_SLOTS-1:0]        key_row_t;
    typedef logic [FLAG_W-1:0]           flags_t;
    typedef logic [EVENT_BITS-1:0]       event_mask_t;

    // One incoming report, unpacked from the input word.
    typedef struct packed {
        logic [7:0] modifier_byte;
        key_row_t   keys;
    } report_t;

    // A report with its pending events: press bits low, release bits high.
    typedef struct packed {
        flags_t      flags;
        key_row_t    cur_keys;
        key_row_t    prev_keys;
        event_mask_t mask;
    } diff_t;

    function automatic flags_t decode_mods(input logic [7:0] m);
        flags_t f;
        f = {m[MOD_ALTGR], m[MOD_RSHIFT], m[MOD_RCTRL],
             m[MOD_ALT], m[MOD_LSHIFT], m[MOD_LCTRL]};
        return f;
    endfunction

endpackage

// ===== hdl/hkrd_report_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkrd_report_if
// Valid/ready channel carrying one boot-protocol keyboard report per word.
// ----------------------------------------------------------------------------
interface hkrd_report_if;
    logic       valid;
    logic       ready;
    logic [7:0] modifier_byte;
    logic [7:0] key_slot0;
    logic [7:0] key_slot1;
    logic [7:0] key_slot2;
    logic [7:0] key_slot3;
    logic [7:0] key_slot4;
    logic [7:0] key_slot5;

    modport source (
        output valid, modifier_byte,
        output key_slot0, key_slot1, key_slot2, key_slot3, key_slot4, key_slot5,
        input  ready
    );
    modport sink (
        input  valid, modifier_byte,
        input  key_slot0, key_slot1, key_slot2, key_slot3, key_slot4, key_slot5,
        output ready
    );
endinterface

// ===== hdl/hkrd_change_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkrd_change_if
// Valid/ready channel carrying one key change event per word.
// ----------------------------------------------------------------------------
interface hkrd_change_if;
    logic       valid;
    logic       ready;
    logic       has_event;
    logic [7:0] event_key;
    logic       is_press;
    logic [5:0] modifier_flags;
    logic       last_of_report;

    modport source (
        output valid, has_event, event_key, is_press, modifier_flags, last_of_report,
        input  ready
    );
    modport sink (
        input  valid, has_event, event_key, is_press, modifier_flags, last_of_report,
        output ready
    );
endinterface

// ===== hdl/hid_keyboard_report_diff.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hid_keyboard_report_diff
// Turns boot-protocol keyboard reports into press and release events.
// ----------------------------------------------------------------------------
//  Channel  Direction  Word
//  -------  ---------  -------------------------------------------------
//  report   in         modifier_byte, key_slot0 .. key_slot5
//  change   out        has_event, event_key, is_press, modifier_flags,
//                      last_of_report
//
// A report with n events (1 to 12, a no-change report counts as one) sends
// n words from the drain stage, one word per cycle while change is not stalled.
// The first word of a report passes through the hold register and then the
// output register before it appears on change.
// The output register lets the next report enter while the last word waits.
// Reset clears the held keys to none and empties both stages.
// A stall on change holds the drain stage and then backs up report.ready.
// ----------------------------------------------------------------------------
module hid_keyboard_report_diff (
    input  logic          clk,
    input  logic          rst_n,
    hkrd_report_if.sink   report,
    hkrd_change_if.source change
);

    hkrd_pkg::report_t report_word;
    hkrd_pkg::diff_t   diff;
    logic              accept;

    assign report_word.modifier_byte = report.modifier_byte;
    assign report_word.keys          = {report.key_slot5, report.key_slot4,
                                        report.key_slot3, report.key_slot2,
                                        report.key_slot1, report.key_slot0};
    assign accept = report.valid && report.ready;

    hkrd_diff u_diff (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .report (report_word),
        .diff   (diff)
    );

    hkrd_drain u_drain (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (report.valid),
        .in_ready (report.ready),
        .diff     (diff),
        .change   (change)
    );

endmodule

// ===== hdl/hkrd_diff.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkrd_diff
// Holds the previous report's keys and marks presses and releases.
// ----------------------------------------------------------------------------
module hkrd_diff (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  hkrd_pkg::report_t report,
    output hkrd_pkg::diff_t   diff
);

    hkrd_pkg::key_row_t prev_keys_reg;
    hkrd_pkg::key_row_t prev_keys_next;
    logic [hkrd_pkg::KEY_SLOTS-1:0] press;
    logic [hkrd_pkg::KEY_SLOTS-1:0] release_bits;

    // A slot is marked only if nonzero, the first slot holding its code, and absent from the other row.
    always_comb
    begin
        for (int i = 0; i < hkrd_pkg::KEY_SLOTS; i++)
        begin
            press[i]        = (report.keys[i] != 8'd0);
            release_bits[i] = (prev_keys_reg[i] != 8'd0);
            for (int j = 0; j < hkrd_pkg::KEY_SLOTS; j++)
            begin
                if (j < i && report.keys[j] == report.keys[i])
                begin
                    press[i] = 1'b0;
                end
                if (prev_keys_reg[j] == report.keys[i])
                begin
                    press[i] = 1'b0;
                end
                if (j < i && prev_keys_reg[j] == prev_keys_reg[i])
                begin
                    release_bits[i] = 1'b0;
                end
                if (report.keys[j] == prev_keys_reg[i])
                begin
                    release_bits[i] = 1'b0;
                end
            end
        end
    end

    assign diff.flags     = hkrd_pkg::decode_mods(report.modifier_byte);
    assign diff.cur_keys  = report.keys;
    assign diff.prev_keys = prev_keys_reg;
    assign diff.mask      = {release_bits, press};

    assign prev_keys_next = accept ? report.keys : prev_keys_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_keys_reg <= '0;
        end
        else
        begin
            prev_keys_reg <= prev_keys_next;
        end
    end

endmodule

// ===== hdl/hkrd_drain.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkrd_drain
// Holds one diffed report and sends its events, one word per cycle while change is not stalled.
// ----------------------------------------------------------------------------
module hkrd_drain (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  hkrd_pkg::diff_t diff,
    hkrd_change_if.source   change
);

    logic                   hold_valid_reg;
    logic                   hold_valid_next;
    hkrd_pkg::diff_t        hold_reg;
    hkrd_pkg::diff_t        hold_next;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   has_event_reg;
    logic                   has_event_next;
    hkrd_pkg::key_t         key_reg;
    hkrd_pkg::key_t         key_next;
    logic                   press_reg;
    logic                   press_next;
    hkrd_pkg::flags_t       flags_reg;
    hkrd_pkg::flags_t       flags_next;
    logic                   last_reg;
    logic                   last_next;

    hkrd_pkg::event_mask_t  low_bit;
    hkrd_pkg::event_mask_t  rest_mask;
    hkrd_pkg::key_t         sel_key;
    logic                   last_item;
    logic                   load_out;
    logic                   in_accept;

    // Lowest pending event; press bits sit below release bits.
    assign low_bit   = hold_reg.mask & (~hold_reg.mask + hkrd_pkg::event_mask_t'(1));
    assign rest_mask = hold_reg.mask & ~low_bit;
    assign last_item = (rest_mask == '0);

    always_comb
    begin
        sel_key = '0;
        for (int i = 0; i < hkrd_pkg::KEY_SLOTS; i++)
        begin
            sel_key = sel_key
                    | ({8{low_bit[i]}} & hold_reg.cur_keys[i])
                    | ({8{low_bit[i + hkrd_pkg::KEY_SLOTS]}} & hold_reg.prev_keys[i]);
        end
    end

    assign load_out  = hold_valid_reg && (!out_valid_reg || change.ready);
    assign in_ready  = !hold_valid_reg || (load_out && last_item);
    assign in_accept = in_valid && in_ready;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        if (in_accept)
        begin
            hold_valid_next = 1'b1;
            hold_next       = diff;
        end
        else if (load_out)
        begin
            hold_valid_next = !last_item;
            hold_next.mask  = rest_mask;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        has_event_next = has_event_reg;
        key_next       = key_reg;
        press_next     = press_reg;
        flags_next     = flags_reg;
        last_next      = last_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            has_event_next = |hold_reg.mask;
            key_next       = sel_key;
            press_next     = |low_bit[hkrd_pkg::KEY_SLOTS-1:0];
            flags_next     = hold_reg.flags;
            last_next      = last_item;
        end
        else if (change.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg      <= hold_next;
        has_event_reg <= has_event_next;
        key_reg       <= key_next;
        press_reg     <= press_next;
        flags_reg     <= flags_next;
        last_reg      <= last_next;
    end

    assign change.valid          = out_valid_reg;
    assign change.has_event      = has_event_reg;
    assign change.event_key      = key_reg;
    assign change.is_press       = press_reg;
    assign change.modifier_flags = flags_reg;
    assign change.last_of_report = last_reg;

    // A word without an event always closes its report.
    a_no_event_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !has_event_reg |-> last_reg)
        else $error("no-event word not marked last");

    // An event word never carries the empty key code.
    a_event_key_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && has_event_reg |-> key_reg != 8'd0)
        else $error("event word with empty key code");

    // Each word sent mid-report retires exactly one pending event.
    a_mask_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        load_out && !last_item |=>
            hold_valid_reg &&
            $countones(hold_reg.mask) == $countones($past(hold_reg.mask)) - 1)
        else $error("pending events not retired one per word");

    // A new report enters only when the held one is gone or finishing.
    a_accept_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && hold_valid_reg |-> load_out && last_item)
        else $error("report accepted over an unfinished one");

endmodule

// ===== tb/sv/tb_hid_keyboard_report_diff.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hid_keyboard_report_diff
// Self-checking bench for the keyboard report differ. Reports go in on the
// report channel and are predicted in the bench into press, release and
// no-change words, which are compared field by field with the change channel.
// ----------------------------------------------------------------------------
module tb_hid_keyboard_report_diff;

    typedef struct {
        logic             has_event;
        hkrd_pkg::key_t   event_key;
        logic             is_press;
        hkrd_pkg::flags_t modifier_flags;
        logic             last_of_report;
    } key_change_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    hkrd_report_if report_bus ();
    hkrd_change_if change_bus ();

    hid_keyboard_report_diff uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .report (report_bus),
        .change (change_bus)
    );

    key_change_t        pending_changes[$];
    hkrd_pkg::key_row_t held_keys;
    int                 fail_count = 0;
    bit                 no_gaps    = 1'b0;
    bit                 hold_req   = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic bit row_has(input hkrd_pkg::key_row_t row, input int count,
                                   input hkrd_pkg::key_t k);
        for (int i = 0; i < count; i++)
        begin
            if (row[i] == k)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void add_word(input key_change_t w);
        pending_changes.insert(pending_changes.size(), w);
    endfunction

    function automatic void predict_changes(input hkrd_pkg::report_t r);
        key_change_t      w;
        hkrd_pkg::flags_t f;
        hkrd_pkg::key_t   k;
        int               n;
        n = 0;
        // GUI keys (modifier bits 3 and 7) have no flag.
        f[0] = r.modifier_byte[hkrd_pkg::MOD_LCTRL];
        f[1] = r.modifier_byte[hkrd_pkg::MOD_LSHIFT];
        f[2] = r.modifier_byte[hkrd_pkg::MOD_ALT];
        f[3] = r.modifier_byte[hkrd_pkg::MOD_RCTRL];
        f[4] = r.modifier_byte[hkrd_pkg::MOD_RSHIFT];
        f[5] = r.modifier_byte[hkrd_pkg::MOD_ALTGR];
        w.modifier_flags = f;
        w.last_of_report = 1'b0;
        w.has_event      = 1'b1;
        // A code repeated within one report only counts at its first slot.
        for (int i = 0; i < hkrd_pkg::KEY_SLOTS; i++)
        begin
            k = r.keys[i];
            if (k != 8'd0 && !row_has(r.keys, i, k) &&
                !row_has(held_keys, hkrd_pkg::KEY_SLOTS, k))
            begin
                w.event_key = k;
                w.is_press  = 1'b1;
                add_word(w);
                n++;
            end
        end
        for (int i = 0; i < hkrd_pkg::KEY_SLOTS; i++)
        begin
            k = held_keys[i];
            if (k != 8'd0 && !row_has(held_keys, i, k) &&
                !row_has(r.keys, hkrd_pkg::KEY_SLOTS, k))
            begin
                w.event_key = k;
                w.is_press  = 1'b0;
                add_word(w);
                n++;
            end
        end
        if (n == 0)
        begin
            w.has_event = 1'b0;
            w.event_key = 8'd0;
            w.is_press  = 1'b0;
            add_word(w);
        end
        pending_changes[pending_changes.size() - 1].last_of_report = 1'b1;
        held_keys = r.keys;
    endfunction

    // ------------------------------------------------------------------
    // Report sender: called at a rising edge, returns at the accepting edge.
    // ------------------------------------------------------------------
    task automatic send_report(input hkrd_pkg::report_t r);
        if (!no_gaps)
        begin
            while ($urandom_range(0, 99) < 20)
            begin
                report_bus.valid <= 1'b0;
                @(posedge clk);
            end
        end
        report_bus.valid         <= 1'b1;
        report_bus.modifier_byte <= r.modifier_byte;
        report_bus.key_slot0     <= r.keys[0];
        report_bus.key_slot1     <= r.keys[1];
        report_bus.key_slot2     <= r.keys[2];
        report_bus.key_slot3     <= r.keys[3];
        report_bus.key_slot4     <= r.keys[4];
        report_bus.key_slot5     <= r.keys[5];
        do
            @(posedge clk);
        while (!report_bus.ready);
        predict_changes(r);
    endtask

    function automatic hkrd_pkg::report_t make_report(input logic [7:0] mods,
                                                      input hkrd_pkg::key_t k0,
                                                      input hkrd_pkg::key_t k1,
                                                      input hkrd_pkg::key_t k2,
                                                      input hkrd_pkg::key_t k3,
                                                      input hkrd_pkg::key_t k4,
                                                      input hkrd_pkg::key_t k5);
        hkrd_pkg::report_t r;
        r.modifier_byte = mods;
        r.keys          = {k5, k4, k3, k2, k1, k0};
        return r;
    endfunction

    function automatic hkrd_pkg::key_t random_key();
        if ($urandom_range(0, 3) == 0)
            return hkrd_pkg::key_t'($urandom_range(0, 255));
        return hkrd_pkg::key_t'($urandom_range(0, 12));
    endfunction

    // ------------------------------------------------------------------
    // Change receiver and checker. Ready is randomized, or held high while no_gaps
    // is set; a hold request from the stimulus side stalls it for a long stretch.
    // ------------------------------------------------------------------
    initial
    begin
        key_change_t want;
        int          hold_left;
        bit          hold_seen;
        hold_left = 0;
        hold_seen = 1'b0;
        change_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && change_bus.valid && change_bus.ready)
            begin
                if (pending_changes.size() == 0)
                begin
                    $error("unexpected change word: key %0h press %0b",
                           change_bus.event_key, change_bus.is_press);
                    fail_count++;
                end
                else
                begin
                    want = pending_changes.pop_front();
                    if (change_bus.has_event !== want.has_event)
                    begin
                        $error("has_event: expected %0b, got %0b",
                               want.has_event, change_bus.has_event);
                        fail_count++;
                    end
                    if (change_bus.event_key !== want.event_key)
                    begin
                        $error("event_key: expected %0h, got %0h",
                               want.event_key, change_bus.event_key);
                        fail_count++;
                    end
                    if (change_bus.is_press !== want.is_press)
                    begin
                        $error("is_press: expected %0b, got %0b",
                               want.is_press, change_bus.is_press);
                        fail_count++;
                    end
                    if (change_bus.modifier_flags !== want.modifier_flags)
                    begin
                        $error("modifier_flags: expected %0h, got %0h",
                               want.modifier_flags, change_bus.modifier_flags);
                        fail_count++;
                    end
                    if (change_bus.last_of_report !== want.last_of_report)
                    begin
                        $error("last_of_report: expected %0b, got %0b",
                               want.last_of_report, change_bus.last_of_report);
                        fail_count++;
                    end
                end
            end
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                hold_left = 200;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                change_bus.ready <= 1'b0;
            end
            else if (no_gaps)
                change_bus.ready <= 1'b1;
            else
                change_bus.ready <= ($urandom_range(0, 99) >= 20);
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_modifier_decode();
        logic [7:0] mods[10] = '{8'h00, 8'hFF, 8'h88, 8'h01, 8'h02, 8'h04,
                                 8'h10, 8'h20, 8'h40, 8'h77};
        foreach (mods[i])
            send_report(make_report(mods[i], 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    endtask

    task automatic test_press_and_release();
        send_report(make_report(8'h02, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_report(make_report(8'h02, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_report(make_report(8'h00, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09));
        // Same keys in other slots is not a change.
        send_report(make_report(8'h00, 8'h09, 8'h08, 8'h07, 8'h06, 8'h05, 8'h04));
        send_report(make_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    endtask

    task automatic test_duplicates_and_error_codes();
        send_report(make_report(8'h11, 8'h10, 8'h10, 8'h11, 8'h10, 8'h11, 8'h00));
        send_report(make_report(8'h00, 8'h01, 8'h02, 8'h03, 8'h10, 8'h00, 8'h01));
        send_report(make_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    endtask

    task automatic test_full_turnover();
        send_report(make_report(8'hFF, 8'hFF, 8'hFE, 8'hFD, 8'hFC, 8'hFB, 8'hFA));
        send_report(make_report(8'h7F, 8'h80, 8'h40, 8'h20, 8'h10, 8'h08, 8'h07));
        send_report(make_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    endtask

    // Mostly a held set that drifts a few slots per report, as real typing
    // does; the rest is fully random reports and all-up reports.
    task automatic test_random_typing(input int count);
        hkrd_pkg::report_t r;
        int                pick;
        r = make_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
            begin
                r.modifier_byte = 8'($urandom_range(0, 255));
                for (int i = 0; i < hkrd_pkg::KEY_SLOTS; i++)
                    r.keys[i] = hkrd_pkg::key_t'($urandom_range(0, 255));
            end
            else if (pick < 15)
                r = make_report(8'($urandom_range(0, 255)),
                                8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
            else
            begin
                if ($urandom_range(0, 3) == 0)
                    r.modifier_byte = 8'($urandom_range(0, 255));
                for (int i = 0; i < hkrd_pkg::KEY_SLOTS; i++)
                begin
                    if ($urandom_range(0, 99) < 30)
                        r.keys[i] = random_key();
                end
            end
            send_report(r);
        end
    endtask

    // The receiver stalls while busy reports keep coming, so the block fills
    // and has to hold off report words.
    task automatic test_backpressure();
        no_gaps  = 1'b1;
        hold_req = ~hold_req;
        for (int i = 0; i < 10; i++)
        begin
            send_report(make_report(8'h15,
                                    hkrd_pkg::key_t'(8'h21 + i), hkrd_pkg::key_t'(8'h31 + i),
                                    hkrd_pkg::key_t'(8'h41 + i), hkrd_pkg::key_t'(8'h51 + i),
                                    hkrd_pkg::key_t'(8'h61 + i), hkrd_pkg::key_t'(8'h71 + i)));
            send_report(make_report(8'h62,
                                    hkrd_pkg::key_t'(8'hA1 + i), hkrd_pkg::key_t'(8'hB1 + i),
                                    hkrd_pkg::key_t'(8'hC1 + i), hkrd_pkg::key_t'(8'hD1 + i),
                                    hkrd_pkg::key_t'(8'hE1 + i), hkrd_pkg::key_t'(8'hF1 - i)));
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin
        held_keys                = '0;
        report_bus.valid         <= 1'b0;
        report_bus.modifier_byte <= 8'd0;
        report_bus.key_slot0     <= 8'd0;
        report_bus.key_slot1     <= 8'd0;
        report_bus.key_slot2     <= 8'd0;
        report_bus.key_slot3     <= 8'd0;
        report_bus.key_slot4     <= 8'd0;
        report_bus.key_slot5     <= 8'd0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_modifier_decode();
        test_press_and_release();
        test_duplicates_and_error_codes();
        test_full_turnover();
        test_random_typing(80);
        no_gaps = 1'b1;
        test_random_typing(50);
        no_gaps = 1'b0;
        test_backpressure();

        report_bus.valid <= 1'b0;
        while (pending_changes.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
